### hdl/mie_pkg.sv
// Package for the binary extended Euclidean modular inverse block.
// Holds widths, register indexes, status and datapath command codes, and the word types.
// No dependencies; every other file in hdl but mie_stream_if imports it.
package mie_pkg;

  localparam int LIMB_W      = 64;
  localparam int FIELD_LIMBS = 4;
  localparam int FIELD_W     = FIELD_LIMBS * LIMB_W;
  localparam int STEP_W      = 12;
  localparam int CFG_INDEX_W = 2;
  localparam int STATUS_W    = 2;
  localparam int OP_W        = 4;

  localparam logic [STEP_W-1:0] STEP_LIMIT = 12'd4095;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS_LIMB0 = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS_LIMB1 = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS_LIMB2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS_LIMB3 = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FAIL = 2'd2;

  typedef logic [OP_W-1:0] dp_op_t;

  // Datapath operations issued by the controller.
  localparam dp_op_t OP_NOP      = 4'd0;
  localparam dp_op_t OP_LOAD     = 4'd1;
  localparam dp_op_t OP_COPY     = 4'd2;
  localparam dp_op_t OP_REDUCE   = 4'd3;
  localparam dp_op_t OP_INIT     = 4'd4;
  localparam dp_op_t OP_HALVE_U  = 4'd5;
  localparam dp_op_t OP_HALVE_V  = 4'd6;
  localparam dp_op_t OP_CMP      = 4'd7;
  localparam dp_op_t OP_VSUB     = 4'd8;
  localparam dp_op_t OP_COF      = 4'd9;
  localparam dp_op_t OP_FIX      = 4'd10;
  localparam dp_op_t OP_RES_A    = 4'd11;
  localparam dp_op_t OP_RES_B    = 4'd12;
  localparam dp_op_t OP_RES_ZERO = 4'd13;
  localparam dp_op_t OP_RES_FAIL = 4'd14;

  typedef struct packed {
    logic [LIMB_W-1:0] value_limb3;
    logic [LIMB_W-1:0] value_limb2;
    logic [LIMB_W-1:0] value_limb1;
    logic [LIMB_W-1:0] value_limb0;
  } value_t;

  typedef struct packed {
    logic [LIMB_W-1:0]   inverse_limb3;
    logic [LIMB_W-1:0]   inverse_limb2;
    logic [LIMB_W-1:0]   inverse_limb1;
    logic [LIMB_W-1:0]   inverse_limb0;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic u_zero;
    logic v_zero;
    logic u_one;
    logic v_one;
    logic u_odd;
    logic v_odd;
    logic carry;
    logic step_limit;
    logic reduce_last;
    logic mod_zero;
    logic mod_one;
  } dp_stat_t;

endpackage

### hdl/mie_stream_if.sv
// Valid/ready stream interface used for the input and result channels.
// The word type is a parameter; the block uses value_t and result_t from mie_pkg.
interface mie_stream_if #(parameter type T = logic);

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

### hdl/mie_dp.sv
// Datapath of the modular inverse block: modulus registers, u, v, a, b, the step counter,
// one shared wide adder/subtractor and the result register. Depends on mie_pkg.
module mie_dp import mie_pkg::*; #(
  parameter int LIMB_COUNT = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LIMB_W-1:0]      cfg_data,
  input  value_t                 value,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  output result_t                result
);

  localparam int W = LIMB_COUNT * LIMB_W;

  logic [LIMB_W-1:0]   modulus [FIELD_LIMBS];
  logic [FIELD_W-1:0]  mod_flat;
  logic [FIELD_W-1:0]  value_flat;
  logic [W-1:0]        mod_w;
  logic [W-1:0]        x_w;

  logic [W-1:0]        u;
  logic [W-1:0]        v;
  logic [W-1:0]        a;
  logic [W-1:0]        b;
  logic [STEP_W-1:0]   cnt;
  logic                dir;
  logic [W-1:0]        res;
  logic [STATUS_W-1:0] res_status;
  logic [FIELD_W-1:0]  res_pad;

  logic [W-1:0]        add_x;
  logic [W-1:0]        add_y;
  logic                add_sub;
  logic [W:0]          add_full;
  logic [W-1:0]        add_sum;
  logic                add_carry;
  logic [W-1:0]        r_sh;
  logic                step_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus[0] <= '0;
      modulus[1] <= '0;
      modulus[2] <= '0;
      modulus[3] <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODULUS_LIMB0: modulus[0] <= cfg_data;
        REG_MODULUS_LIMB1: modulus[1] <= cfg_data;
        REG_MODULUS_LIMB2: modulus[2] <= cfg_data;
        REG_MODULUS_LIMB3: modulus[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Limbs beyond the field count read as zero; limbs beyond LIMB_COUNT are dropped.
  assign mod_flat   = {modulus[3], modulus[2], modulus[1], modulus[0]};
  assign value_flat = value;
  assign mod_w      = W'(mod_flat);
  assign x_w        = W'(value_flat);

  // During reduction u is the partial remainder and v shifts the dividend out at the top.
  assign r_sh = {u[W-2:0], v[W-1]};

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (cmd.op)
      OP_REDUCE: begin
        add_x   = r_sh;
        add_y   = mod_w;
        add_sub = 1'b1;
      end
      OP_HALVE_U: begin
        add_x = a;
        add_y = a[0] ? mod_w : '0;
      end
      OP_HALVE_V: begin
        add_x = b;
        add_y = b[0] ? mod_w : '0;
      end
      OP_CMP: begin
        add_x   = u;
        add_y   = v;
        add_sub = 1'b1;
      end
      OP_VSUB: begin
        add_x   = v;
        add_y   = u;
        add_sub = 1'b1;
      end
      OP_COF: begin
        add_x   = dir ? b : a;
        add_y   = dir ? a : b;
        add_sub = 1'b1;
      end
      OP_FIX: begin
        add_x = dir ? b : a;
        add_y = mod_w;
      end
      default: ;
    endcase
  end

  // For a subtraction the carry out is high when there was no borrow.
  assign add_full  = {1'b0, add_x} + {1'b0, add_y ^ {W{add_sub}}} + {{W{1'b0}}, add_sub};
  assign add_sum   = add_full[W-1:0];
  assign add_carry = add_full[W];

  assign step_op = (cmd.op == OP_HALVE_U) || (cmd.op == OP_HALVE_V) || (cmd.op == OP_CMP) ||
                   (cmd.op == OP_REDUCE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if ((cmd.op == OP_LOAD) || (cmd.op == OP_INIT)) begin
      cnt <= '0;
    end else if (step_op) begin
      cnt <= cnt + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        u <= '0;
        v <= x_w;
      end
      OP_COPY: begin
        u <= v;
      end
      OP_REDUCE: begin
        // Subtract when the shifted remainder overflowed or is not below the modulus.
        u <= (u[W-1] || add_carry) ? add_sum : r_sh;
        v <= {v[W-2:0], 1'b0};
      end
      OP_INIT: begin
        v <= mod_w;
        a <= stat.mod_one ? '0 : W'(1);
        b <= '0;
      end
      OP_HALVE_U: begin
        u <= {1'b0, u[W-1:1]};
        a <= {add_carry, add_sum[W-1:1]};
      end
      OP_HALVE_V: begin
        v <= {1'b0, v[W-1:1]};
        b <= {add_carry, add_sum[W-1:1]};
      end
      OP_CMP: begin
        if (add_carry) begin
          u   <= add_sum;
          dir <= 1'b0;
        end else begin
          dir <= 1'b1;
        end
      end
      OP_VSUB: begin
        v <= add_sum;
      end
      OP_COF, OP_FIX: begin
        if (dir) begin
          b <= add_sum;
        end else begin
          a <= add_sum;
        end
      end
      OP_RES_A: begin
        res        <= a;
        res_status <= STATUS_OK;
      end
      OP_RES_B: begin
        res        <= b;
        res_status <= STATUS_OK;
      end
      OP_RES_ZERO: begin
        res        <= '0;
        res_status <= STATUS_ZERO;
      end
      OP_RES_FAIL: begin
        res        <= '0;
        res_status <= STATUS_FAIL;
      end
      default: ;
    endcase
  end

  assign stat.u_zero      = (u == '0);
  assign stat.v_zero      = (v == '0);
  assign stat.u_one       = (u == W'(1));
  assign stat.v_one       = (v == W'(1));
  assign stat.u_odd       = u[0];
  assign stat.v_odd       = v[0];
  assign stat.carry       = add_carry;
  assign stat.step_limit  = (cnt >= STEP_LIMIT);
  assign stat.reduce_last = (cnt == STEP_W'(W - 1));
  assign stat.mod_zero    = (mod_w == '0);
  assign stat.mod_one     = (mod_w == W'(1));

  assign res_pad              = FIELD_W'(res);
  assign result.inverse_limb0 = res_pad[0*LIMB_W +: LIMB_W];
  assign result.inverse_limb1 = res_pad[1*LIMB_W +: LIMB_W];
  assign result.inverse_limb2 = res_pad[2*LIMB_W +: LIMB_W];
  assign result.inverse_limb3 = res_pad[3*LIMB_W +: LIMB_W];
  assign result.status        = res_status;

endmodule

### hdl/mie_ctrl.sv
// Controller of the modular inverse block: sequences load, reduction, the inverse steps
// and the result, and owns both handshakes. Depends on mie_pkg.
module mie_ctrl import mie_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_REDUCE = 3'd2;
  localparam logic [2:0] S_INIT   = 3'd3;
  localparam logic [2:0] S_LOOP   = 3'd4;
  localparam logic [2:0] S_VSUB   = 3'd5;
  localparam logic [2:0] S_COF    = 3'd6;
  localparam logic [2:0] S_FIX    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       slot_free;
  logic       res_issue;

  // A result may only be written when the output register is empty or being emptied.
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.v_zero) begin
          if (slot_free) begin
            cmd.op     = OP_RES_ZERO;
            state_next = S_IDLE;
          end
        end else if (stat.mod_zero) begin
          cmd.op     = OP_COPY;
          state_next = S_INIT;
        end else begin
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.op = OP_REDUCE;
        if (stat.reduce_last) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.op     = OP_INIT;
        state_next = S_LOOP;
      end
      S_LOOP: begin
        if (stat.u_zero || stat.v_zero) begin
          if (slot_free) begin
            cmd.op     = OP_RES_FAIL;
            state_next = S_IDLE;
          end
        end else if (stat.u_one) begin
          if (slot_free) begin
            cmd.op     = OP_RES_A;
            state_next = S_IDLE;
          end
        end else if (stat.v_one) begin
          if (slot_free) begin
            cmd.op     = OP_RES_B;
            state_next = S_IDLE;
          end
        end else if (stat.step_limit) begin
          if (slot_free) begin
            cmd.op     = OP_RES_FAIL;
            state_next = S_IDLE;
          end
        end else if (!stat.u_odd) begin
          cmd.op = OP_HALVE_U;
        end else if (!stat.v_odd) begin
          cmd.op = OP_HALVE_V;
        end else begin
          // Both odd: u - v decides the direction; when u is smaller, v - u follows.
          cmd.op     = OP_CMP;
          state_next = stat.carry ? S_COF : S_VSUB;
        end
      end
      S_VSUB: begin
        cmd.op     = OP_VSUB;
        state_next = S_COF;
      end
      S_COF: begin
        cmd.op     = OP_COF;
        state_next = stat.carry ? S_LOOP : S_FIX;
      end
      S_FIX: begin
        cmd.op     = OP_FIX;
        state_next = S_LOOP;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res_issue = (cmd.op == OP_RES_A) || (cmd.op == OP_RES_B) ||
                     (cmd.op == OP_RES_ZERO) || (cmd.op == OP_RES_FAIL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_issue) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

### hdl/modular_inverse_binary_euclid.sv
// Channel   Direction  Word       Fields
// in_ch     sink       value_t    value_limb0..value_limb3 (64 bits each)
// out_ch    source     result_t   inverse_limb0..inverse_limb3 (64 bits each), status (2 bits)
// cfg       write      64 bits    modulus_limb0..modulus_limb3 at indexes 0..3
//
// One word is worked on at a time. A zero value goes from the check straight to the result.
// Otherwise a check, a restoring reduction of the value (skipped for a zero modulus) and a
// setup step come first; then each halving step and each subtract step (compare, v - u if u
// is smaller, cofactor subtract, modulus fix-up on a borrow) uses the one shared wide adder,
// with at most 4095 steps. Reset clears the controller, the step counter and the modulus to zero.
// The next word is accepted while a finished result still waits in the output register;
// a further result waits in the controller until that register is free.
module modular_inverse_binary_euclid import mie_pkg::*; #(
  parameter int LIMB_COUNT = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LIMB_W-1:0]      cfg_data,
  mie_stream_if.sink             in_ch,
  mie_stream_if.source           out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  result_t  result;
  value_t   value;
  logic     in_ready;
  logic     out_valid;

  assign value = in_ch.data;

  mie_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mie_dp #(
    .LIMB_COUNT (LIMB_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .value     (value),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = result;

endmodule

### hdl/mie_checker.sv
// Port-level checks for the modular inverse block, bound to the top level.
// Depends on mie_pkg and sees only the top level's channel signals.
module mie_checker import mie_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  // A result word stays offered until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word withdrawn before it was taken");

  // Every failed or zero result carries an all-zero inverse.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != STATUS_OK) |->
      (out_data.inverse_limb0 == '0) && (out_data.inverse_limb1 == '0) &&
      (out_data.inverse_limb2 == '0) && (out_data.inverse_limb3 == '0))
    else $error("nonzero inverse with a failure status");

  // Once a word is taken the block is busy with it in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is still being worked on");

  // A new result appears exactly as the block returns to idle.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result presented while the block is still busy");

endmodule

bind modular_inverse_binary_euclid mie_checker u_mie_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
